FILE: rtl/core/zcd_pkg.sv
// Package for the text-code decoder: result kinds, alphabet and escape codes,
// the result record and the alphabet lookup. No dependencies.
`default_nettype none

package zcd_pkg;

  localparam int unsigned ZCHAR_W = 5;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned ABBR_W  = 7;
  localparam int unsigned ESCV_W  = 2 * ZCHAR_W;

  localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ABBREV = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ALPHA_LOWER = 2'd0;
  localparam logic [1:0] ALPHA_UPPER = 2'd1;
  localparam logic [1:0] ALPHA_PUNCT = 2'd2;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam logic [ZCHAR_W-1:0] ZC_SPACE      = 5'd0;
  localparam logic [ZCHAR_W-1:0] ZC_FIRST_ALPH = 5'd4;
  localparam logic [ZCHAR_W-1:0] ZC_SHIFT_UP   = 5'd4;
  localparam logic [ZCHAR_W-1:0] ZC_SHIFT_PUNC = 5'd5;
  localparam logic [ZCHAR_W-1:0] ZC_ESCAPE     = 5'd6;

  localparam logic [ESCV_W-1:0] ESC_MIN = 10'd32;
  localparam logic [ESCV_W-1:0] ESC_MAX = 10'd126;

  localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'd32;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [CHAR_W-1:0] character;
    logic [ABBR_W-1:0] abbreviation_index;
  } result_t;

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [1:0] alpha,
                                                   input logic [ZCHAR_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = 7'd0;
    unique case (alpha)
      ALPHA_UPPER: c = 7'd65 + {2'b00, idx};
      ALPHA_PUNCT: begin
        unique case (idx)
          5'd0:  c = 7'd32;
          5'd1:  c = 7'd10;
          5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11:
                 c = 7'd46 + {2'b00, idx};
          5'd12: c = 7'd46;
          5'd13: c = 7'd44;
          5'd14: c = 7'd33;
          5'd15: c = 7'd63;
          5'd16: c = 7'd95;
          5'd17: c = 7'd35;
          5'd18: c = 7'd39;
          5'd19: c = 7'd34;
          5'd20: c = 7'd47;
          5'd21: c = 7'd92;
          5'd22: c = 7'd45;
          5'd23: c = 7'd58;
          5'd24: c = 7'd40;
          5'd25: c = 7'd41;
          default: c = 7'd0;
        endcase
      end
      default: c = 7'd97 + {2'b00, idx};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/zcd_if.sv
// Valid/ready channel interfaces for text codes in and decoded results out.
// Depends on zcd_pkg for field widths.
`default_nettype none

interface zcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [zcd_pkg::ZCHAR_W-1:0] zchar;
  logic                        last_of_string;
  logic                        abbreviations_allowed;

  modport source (output valid, zchar, last_of_string, abbreviations_allowed, input ready);
  modport sink   (input valid, zchar, last_of_string, abbreviations_allowed, output ready);
endinterface

interface zcd_out_if;
  logic                       valid;
  logic                       ready;
  logic [zcd_pkg::KIND_W-1:0] result_kind;
  logic [zcd_pkg::CHAR_W-1:0] character;
  logic [zcd_pkg::ABBR_W-1:0] abbreviation_index;

  modport source (output valid, result_kind, character, abbreviation_index, input ready);
  modport sink   (input valid, result_kind, character, abbreviation_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/zcd_decode.sv
// Decoder state (shift, escape, abbreviation bank) and the per-code decode.
// Depends on zcd_pkg.
`default_nettype none

module zcd_decode (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [zcd_pkg::ZCHAR_W-1:0] zchar,
  input  wire logic                        last_of_string,
  input  wire logic                        abbreviations_allowed,
  output logic                             res_valid,
  output zcd_pkg::result_t                 res
);

  logic [1:0]                  shift_r, shift_nxt;
  logic [1:0]                  esc_phase_r, esc_phase_nxt;
  logic [zcd_pkg::ZCHAR_W-1:0] esc_high_r, esc_high_nxt;
  logic [1:0]                  bank_r, bank_nxt;
  logic [1:0]                  alpha;
  logic [zcd_pkg::ESCV_W-1:0]  esc_value;
  logic [1:0]                  bank_m1;
  logic                        err;

  assign alpha     = (shift_r == 2'd3) ? zcd_pkg::ALPHA_LOWER : shift_r;
  assign esc_value = {esc_high_r, zchar};
  assign bank_m1   = bank_r - 2'd1;

  always_comb begin
    shift_nxt     = zcd_pkg::ALPHA_LOWER;
    esc_phase_nxt = esc_phase_r;
    esc_high_nxt  = esc_high_r;
    bank_nxt      = bank_r;
    res_valid     = 1'b0;
    err           = 1'b0;
    res           = '0;
    res.result_kind = zcd_pkg::KIND_CHAR;
    priority if (esc_phase_r == zcd_pkg::ESC_HIGH) begin
      esc_high_nxt  = zchar;
      esc_phase_nxt = zcd_pkg::ESC_LOW;
    end else if (esc_phase_r == zcd_pkg::ESC_LOW) begin
      esc_phase_nxt = zcd_pkg::ESC_NONE;
      esc_high_nxt  = '0;
      res_valid     = 1'b1;
      if (esc_value >= zcd_pkg::ESC_MIN && esc_value <= zcd_pkg::ESC_MAX) begin
        res.character = esc_value[zcd_pkg::CHAR_W-1:0];
      end else begin
        res.result_kind = zcd_pkg::KIND_ERROR;
        err             = 1'b1;
      end
    end else if (bank_r != 2'd0) begin
      res_valid              = 1'b1;
      res.result_kind        = zcd_pkg::KIND_ABBREV;
      res.abbreviation_index = {bank_m1, zchar};
      esc_phase_nxt          = zcd_pkg::ESC_NONE;
      esc_high_nxt           = '0;
      bank_nxt               = 2'd0;
    end else if (zchar == zcd_pkg::ZC_SPACE) begin
      res_valid     = 1'b1;
      res.character = zcd_pkg::ASCII_SPACE;
    end else if (zchar < zcd_pkg::ZC_FIRST_ALPH) begin
      if (abbreviations_allowed) begin
        bank_nxt = zchar[1:0];
      end else begin
        res_valid       = 1'b1;
        res.result_kind = zcd_pkg::KIND_ERROR;
        err             = 1'b1;
      end
    end else if (zchar == zcd_pkg::ZC_SHIFT_UP) begin
      shift_nxt = zcd_pkg::ALPHA_UPPER;
    end else if (zchar == zcd_pkg::ZC_SHIFT_PUNC) begin
      shift_nxt = zcd_pkg::ALPHA_PUNCT;
    end else if (zchar == zcd_pkg::ZC_ESCAPE && alpha == zcd_pkg::ALPHA_PUNCT) begin
      esc_phase_nxt = zcd_pkg::ESC_HIGH;
      esc_high_nxt  = '0;
    end else begin
      res_valid     = 1'b1;
      res.character = zcd_pkg::alpha_char(alpha, zchar - zcd_pkg::ZC_ESCAPE);
    end
    if (err || last_of_string) begin
      shift_nxt     = zcd_pkg::ALPHA_LOWER;
      esc_phase_nxt = zcd_pkg::ESC_NONE;
      esc_high_nxt  = '0;
      bank_nxt      = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= zcd_pkg::ALPHA_LOWER;
      esc_phase_r <= zcd_pkg::ESC_NONE;
      esc_high_r  <= '0;
      bank_r      <= 2'd0;
    end else if (step) begin
      shift_r     <= shift_nxt;
      esc_phase_r <= esc_phase_nxt;
      esc_high_r  <= esc_high_nxt;
      bank_r      <= bank_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/zchar_text_decoder.sv
// Top level of the text-code decoder: input register, decoder, result register.
// Depends on zcd_pkg, zcd_in_if, zcd_out_if and zcd_decode.
//
// Takes one 5-bit text code per cycle and returns at most one result per code
// (character, abbreviation request or error) via the input register, the decoder
// and the result register. Codes that only update state (shifts, escape and
// abbreviation prefixes) produce no result. Throughput is one code per clock,
// set by the decoder state update; a stalled result port holds the pipeline.
`default_nettype none

module zchar_text_decoder (
  input  wire logic  clk,
  input  wire logic  rst_n,
  zcd_in_if.sink     in_ch,
  zcd_out_if.source  out_ch
);

  logic                        s1_valid_r;
  logic [zcd_pkg::ZCHAR_W-1:0] s1_zchar_r;
  logic                        s1_last_r;
  logic                        s1_allowed_r;
  logic                        out_valid_r;
  zcd_pkg::result_t            out_res_r;
  logic                        out_free;
  logic                        s1_adv;
  logic                        in_xfer;
  logic                        res_valid;
  zcd_pkg::result_t            res;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_zchar_r   <= in_ch.zchar;
      s1_last_r    <= in_ch.last_of_string;
      s1_allowed_r <= in_ch.abbreviations_allowed;
    end
  end

  zcd_decode u_decode (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .step                  (s1_adv),
    .zchar                 (s1_zchar_r),
    .last_of_string        (s1_last_r),
    .abbreviations_allowed (s1_allowed_r),
    .res_valid             (res_valid),
    .res                   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.result_kind        = out_res_r.result_kind;
  assign out_ch.character          = out_res_r.character;
  assign out_ch.abbreviation_index = out_res_r.abbreviation_index;

endmodule

`default_nettype wire
